// ===== design/bas_pkg.sv =====
// Package for the barometric altitude smoother: word types, register indexes,
// widths, reset values and the sequencer state type.
// No dependencies.
package bas_pkg;

    localparam int SAMPLE_BITS_DEF = 24;
    localparam int TEMP_FRAC_DEF   = 8;
    localparam int DIG_W           = 4;

    localparam int RAW_W      = 24;
    localparam int WEIGHT_W   = 9;
    localparam int OFFSET_W   = 27;
    localparam int SLOPE_W    = 20;
    localparam int WARMUP_W   = 4;
    localparam int COMP_W     = 24;
    localparam int CFG_DATA_W = 27;
    localparam int CFG_IDX_W  = 3;

    localparam int TEMP_W   = 32;
    localparam int PRESS_W  = 27;
    localparam int CHANGE_W = 40;
    localparam int ALT_W    = 44;

    localparam int PRESS_SHIFT  = 16;
    localparam int SMOOTH_SHIFT = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOPE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WARMUP = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COMP   = 3'd4;

    localparam logic [WEIGHT_W-1:0] WEIGHT_RST = 9'd51;
    localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = 9'd256;
    localparam logic [OFFSET_W-1:0] OFFSET_RST = 27'd89476301;
    localparam logic [SLOPE_W-1:0]  SLOPE_RST  = 20'd324509;
    localparam logic [WARMUP_W-1:0] WARMUP_RST = 4'd5;
    localparam logic [WARMUP_W-1:0] WARM_MAX   = 4'd15;
    localparam logic [COMP_W-1:0]   COMP_RST   = '0;

    localparam logic signed [CHANGE_W-1:0] CHG_MAX = {1'b0, {(CHANGE_W-1){1'b1}}};
    localparam logic signed [CHANGE_W-1:0] CHG_MIN = {1'b1, {(CHANGE_W-1){1'b0}}};

    typedef struct packed {
        logic [RAW_W-1:0] raw_temperature;
        logic [RAW_W-1:0] raw_pressure;
    } t_in_word;

    typedef struct packed {
        logic [TEMP_W-1:0]          smooth_temperature;
        logic [PRESS_W-1:0]         smooth_pressure;
        logic signed [CHANGE_W-1:0] pressure_change;
        logic signed [ALT_W-1:0]    altitude;
        logic                       baseline_ready;
    } t_out_word;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PMUL,
        ST_SAMPLE,
        ST_DELTA,
        ST_WMUL,
        ST_AVG,
        ST_DIFF,
        ST_CMUL,
        ST_RND,
        ST_CHG,
        ST_ALT,
        ST_DONE
    } t_state;

endpackage

// ===== design/baro_altitude_smoother.sv =====
// Barometric altitude smoother: sample conversion, EMA smoothing, baseline latch,
// compensated pressure change and altitude, all multiplies done 4 bits a cycle.
// Depends on bas_pkg.
//
//  channel | direction | handshake                    | payload
//  in      | in        | i_in_valid / o_in_ready      | i_in_word   (t_in_word)
//  out     | out       | o_out_valid / i_out_ready    | o_out_word  (t_out_word)
//  cfg     | in        | i_cfg_we                     | i_cfg_index, i_cfg_data
//
// One word at a time: the compensation multiply, rounding and change steps run only once the
// baseline is latched; before that, the change and altitude stay zero.
// Every multiply (slope, weight, compensation) is a radix-16 shift-add multiplier.
// Reset is synchronous, active low; it restores register defaults, filter state and sequencer.
// The result register frees the sequencer: a new word is taken the cycle after a result loads,
// even while it waits; the last state stalls only while the previous result is still held.
module baro_altitude_smoother #(
    parameter int SAMPLE_BITS        = bas_pkg::SAMPLE_BITS_DEF,
    parameter int TEMP_FRACTION_BITS = bas_pkg::TEMP_FRAC_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  bas_pkg::t_in_word                 i_in_word,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output bas_pkg::t_out_word                o_out_word,
    input  logic                              i_cfg_we,
    input  logic [bas_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [bas_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import bas_pkg::*;

    localparam int PD        = (SAMPLE_BITS + DIG_W - 1) / DIG_W;
    localparam int WD        = (WEIGHT_W + DIG_W - 1) / DIG_W;
    localparam int CD        = COMP_W / DIG_W;
    localparam int MAX_STEPS = (PD > CD) ? PD : CD;
    localparam int STEP_W    = $clog2(MAX_STEPS);
    localparam int PMW       = PD * DIG_W;
    localparam int WMW       = WD * DIG_W;
    localparam int DSW       = (PMW > COMP_W) ? PMW : COMP_W;
    localparam int PAW       = SLOPE_W + PMW;
    localparam int PPW       = SLOPE_W + DIG_W;
    localparam int PDW       = PAW + 1 - PRESS_SHIFT;
    localparam int CMPW      = (PDW > PRESS_W) ? PDW : PRESS_W;
    localparam int TW        = (SAMPLE_BITS + TEMP_FRACTION_BITS > TEMP_W) ?
                               SAMPLE_BITS + TEMP_FRACTION_BITS : TEMP_W + 1;
    localparam int DTW       = TEMP_W + 1;
    localparam int DPW       = PRESS_W + 1;
    localparam int ATW       = DTW + WMW + 1;
    localparam int APW       = DPW + WMW + 1;
    localparam int PTW       = DTW + DIG_W + 1;
    localparam int PWW       = DPW + DIG_W + 1;
    localparam int ACW       = DTW + COMP_W;
    localparam int SUMW      = ACW + 1;

    localparam logic [PAW:0]            P_RND = (PAW + 1)'(1) << (PRESS_SHIFT - 1);
    localparam logic [ATW-1:0]          T_RND = ATW'(1) << (SMOOTH_SHIFT - 1);
    localparam logic [APW-1:0]          W_RND = APW'(1) << (SMOOTH_SHIFT - 1);
    localparam logic signed [ACW-1:0]   C_RND = ACW'(1) << (TEMP_FRACTION_BITS - 1);

    // configuration and filter state
    logic [WEIGHT_W-1:0]      r_weight;
    logic [OFFSET_W-1:0]      r_offset;
    logic [SLOPE_W-1:0]       r_slope;
    logic [WARMUP_W-1:0]      r_warmup;
    logic signed [COMP_W-1:0] r_comp;
    logic [TEMP_W-1:0]        r_t_avg, r_t_base;
    logic [PRESS_W-1:0]       r_p_avg, r_p_base;
    logic [WARMUP_W-1:0]      r_warm_cnt;
    logic                     r_latched;

    // sequencer
    t_state                   r_state, n_state;
    logic [STEP_W-1:0]        r_step;
    logic                     r_out_valid;
    t_out_word                r_out;
    logic                     out_load;

    // datapath
    logic [SAMPLE_BITS-1:0]   r_raw_t;
    logic [DSW-1:0]           r_digits;
    logic [PAW-1:0]           r_acc_p;
    logic [PRESS_W-1:0]       r_p_smp;
    logic signed [DTW-1:0]    r_d_t;
    logic signed [DPW-1:0]    r_d_p;
    logic signed [ATW-1:0]    r_acc_t;
    logic signed [APW-1:0]    r_acc_w;
    logic signed [ACW-1:0]    r_acc_c;
    logic signed [CHANGE_W-1:0] r_chg;
    logic signed [ALT_W-1:0]  r_alt;

    logic [DIG_W-1:0]         dig;
    logic signed [DIG_W:0]    dig_u, dig_c;
    logic [PPW-1:0]           pp_p;
    logic signed [PTW-1:0]    pp_t, pp_c;
    logic signed [PWW-1:0]    pp_w;
    logic                     last_p, last_w, last_c;
    logic [PAW:0]             p_round;
    logic [PDW-1:0]           p_drop;
    logic [CMPW-1:0]          p_diff;
    logic [PRESS_W-1:0]       p_smp;
    logic [TW-1:0]            t_wide;
    logic [TEMP_W-1:0]        t_smp;
    logic [WEIGHT_W-1:0]      w_eff;
    logic [ATW-1:0]           t_sum;
    logic [APW-1:0]           w_sum;
    logic [TEMP_W-1:0]        t_new;
    logic [PRESS_W-1:0]       p_new;
    logic [WARMUP_W-1:0]      cnt_n;
    logic                     latch_now;
    logic signed [SUMW-1:0]   chg_sum;
    logic                     chg_ovf;
    logic signed [CHANGE_W-1:0] chg_sat;
    logic signed [ALT_W-1:0]  alt_n;

    // digit multipliers
    assign dig    = r_digits[DSW-1 -: DIG_W];
    assign dig_u  = {1'b0, dig};
    assign dig_c  = (r_step == '0) ? {dig[DIG_W-1], dig} : {1'b0, dig};
    assign pp_p   = PPW'(r_slope) * PPW'(dig);
    assign pp_t   = PTW'(r_d_t) * PTW'(dig_u);
    assign pp_w   = PWW'(r_d_p) * PWW'(dig_u);
    assign pp_c   = PTW'(r_d_t) * PTW'(dig_c);
    assign last_p = (r_step == STEP_W'(PD - 1));
    assign last_w = (r_step == STEP_W'(WD - 1));
    assign last_c = (r_step == STEP_W'(CD - 1));

    // sample conversion
    assign p_round = (PAW + 1)'(r_acc_p) + P_RND;
    assign p_drop  = p_round[PAW:PRESS_SHIFT];
    assign p_diff  = CMPW'(r_offset) - CMPW'(p_drop);
    assign p_smp   = (CMPW'(p_drop) >= CMPW'(r_offset)) ? '0 : p_diff[PRESS_W-1:0];
    assign t_wide  = TW'(r_raw_t) << TEMP_FRACTION_BITS;
    assign t_smp   = (|t_wide[TW-1:TEMP_W]) ? '1 : t_wide[TEMP_W-1:0];
    assign w_eff   = (r_weight > WEIGHT_MAX) ? WEIGHT_MAX : r_weight;

    // smoother update: avg + (w*(s-avg) + 128) >> 8, always non-negative
    assign t_sum     = ATW'(r_acc_t) + T_RND + (ATW'(r_t_avg) << SMOOTH_SHIFT);
    assign w_sum     = APW'(r_acc_w) + W_RND + (APW'(r_p_avg) << SMOOTH_SHIFT);
    assign t_new     = t_sum[SMOOTH_SHIFT +: TEMP_W];
    assign p_new     = w_sum[SMOOTH_SHIFT +: PRESS_W];
    assign cnt_n     = (r_warm_cnt == WARM_MAX) ? r_warm_cnt : r_warm_cnt + 1'b1;
    assign latch_now = !r_latched && (cnt_n >= r_warmup);

    // pressure change and altitude
    assign chg_sum = SUMW'(r_d_p) + SUMW'(r_acc_c);
    assign chg_ovf = !((&chg_sum[SUMW-1:CHANGE_W-1]) || !(|chg_sum[SUMW-1:CHANGE_W-1]));
    assign chg_sat = chg_ovf ? (chg_sum[SUMW-1] ? CHG_MIN : CHG_MAX)
                             : chg_sum[CHANGE_W-1:0];
    assign alt_n   = -((ALT_W'(r_chg) <<< 3) + (ALT_W'(r_chg) <<< 1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (i_in_valid) n_state = ST_PMUL;
            ST_PMUL:   if (last_p) n_state = ST_SAMPLE;
            ST_SAMPLE: n_state = ST_DELTA;
            ST_DELTA:  n_state = ST_WMUL;
            ST_WMUL:   if (last_w) n_state = ST_AVG;
            ST_AVG:    n_state = ST_DIFF;
            ST_DIFF:   n_state = r_latched ? ST_CMUL : ST_ALT;
            ST_CMUL:   if (last_c) n_state = ST_RND;
            ST_RND:    n_state = ST_CHG;
            ST_CHG:    n_state = ST_ALT;
            ST_ALT:    n_state = ST_DONE;
            ST_DONE:   if (!r_out_valid || i_out_ready) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = (r_state == ST_IDLE);
        out_load   = (r_state == ST_DONE) && (!r_out_valid || i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
            r_weight    <= WEIGHT_RST;
            r_offset    <= OFFSET_RST;
            r_slope     <= SLOPE_RST;
            r_warmup    <= WARMUP_RST;
            r_comp      <= COMP_RST;
            r_t_avg     <= '0;
            r_p_avg     <= '0;
            r_t_base    <= '0;
            r_p_base    <= '0;
            r_warm_cnt  <= '0;
            r_latched   <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_WEIGHT: r_weight <= i_cfg_data[WEIGHT_W-1:0];
                    CFG_OFFSET: r_offset <= i_cfg_data[OFFSET_W-1:0];
                    CFG_SLOPE:  r_slope  <= i_cfg_data[SLOPE_W-1:0];
                    CFG_WARMUP: r_warmup <= i_cfg_data[WARMUP_W-1:0];
                    CFG_COMP:   r_comp   <= i_cfg_data[COMP_W-1:0];
                    default: ;
                endcase
            end

            if ((r_state == ST_PMUL && !last_p) || (r_state == ST_WMUL && !last_w) ||
                (r_state == ST_CMUL && !last_c)) begin
                r_step <= r_step + 1'b1;
            end else begin
                r_step <= '0;
            end

            if (r_state == ST_AVG) begin
                r_t_avg <= t_new;
                r_p_avg <= p_new;
                if (!r_latched) begin
                    r_warm_cnt <= cnt_n;
                end
                if (latch_now) begin
                    r_t_base  <= t_new;
                    r_p_base  <= p_new;
                    r_latched <= 1'b1;
                end
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_raw_t  <= i_in_word.raw_temperature[SAMPLE_BITS-1:0];
                r_digits <= DSW'(PMW'(i_in_word.raw_pressure[SAMPLE_BITS-1:0])) << (DSW - PMW);
                r_acc_p  <= '0;
            end
            ST_PMUL: begin
                r_acc_p  <= (r_acc_p << DIG_W) + PAW'(pp_p);
                r_digits <= r_digits << DIG_W;
            end
            ST_SAMPLE: begin
                r_p_smp <= p_smp;
            end
            ST_DELTA: begin
                r_d_t    <= DTW'(t_smp) - DTW'(r_t_avg);
                r_d_p    <= DPW'(r_p_smp) - DPW'(r_p_avg);
                r_digits <= DSW'(WMW'(w_eff)) << (DSW - WMW);
                r_acc_t  <= '0;
                r_acc_w  <= '0;
            end
            ST_WMUL: begin
                r_acc_t  <= (r_acc_t <<< DIG_W) + ATW'(pp_t);
                r_acc_w  <= (r_acc_w <<< DIG_W) + APW'(pp_w);
                r_digits <= r_digits << DIG_W;
            end
            ST_AVG: ;
            ST_DIFF: begin
                r_d_t    <= DTW'(r_t_avg) - DTW'(r_t_base);
                r_d_p    <= DPW'(r_p_avg) - DPW'(r_p_base);
                r_digits <= DSW'(r_comp) << (DSW - COMP_W);
                r_acc_c  <= '0;
                r_chg    <= '0;
            end
            ST_CMUL: begin
                r_acc_c  <= (r_acc_c <<< DIG_W) + ACW'(pp_c);
                r_digits <= r_digits << DIG_W;
            end
            ST_RND: begin
                r_acc_c <= (r_acc_c + C_RND) >>> TEMP_FRACTION_BITS;
            end
            ST_CHG: begin
                r_chg <= chg_sat;
            end
            ST_ALT: begin
                r_alt <= alt_n;
            end
            ST_DONE: begin
                if (out_load) begin
                    r_out.smooth_temperature <= r_t_avg;
                    r_out.smooth_pressure    <= r_p_avg;
                    r_out.pressure_change    <= r_chg;
                    r_out.altitude           <= r_alt;
                    r_out.baseline_ready     <= r_latched;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    a_latch_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_latched |=> r_latched)
        else $error("baseline flag dropped without reset");

    a_zero_before_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_word.baseline_ready) |->
        (o_out_word.pressure_change == '0) && (o_out_word.altitude == '0))
        else $error("nonzero change before baseline");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == ST_PMUL) && !o_in_ready)
        else $error("accepted word did not start conversion");

    a_cmul_latched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CMUL) |-> (r_latched && (r_step < STEP_W'(CD))))
        else $error("compensation multiply without baseline or past last digit");

endmodule

// ===== tb/sv/baro_altitude_smoother_tb.sv =====
// Testbench for baro_altitude_smoother: drives sample pairs and register writes,
// predicts each reading in-line and checks every output word field by field.
// Depends on bas_pkg and baro_altitude_smoother.
module baro_altitude_smoother_tb;
    import bas_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 3'd7;
    localparam longint ALT_HI = 64'sd8796093022207;
    localparam longint ALT_LO = -64'sd8796093022208;
    localparam int SETTLE_CYCLES = 30;

    logic                  i_clk;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    t_in_word              i_in_word = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_word             o_out_word;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    baro_altitude_smoother dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    t_in_word  sample_q[$];
    t_out_word reading_q[$];
    int        n_samples_queued = 0;
    int        n_samples_taken = 0;
    int        n_readings = 0;
    int        n_errors = 0;
    logic      in_fire = 1'b0;
    logic      out_fire = 1'b0;
    int        gap_left = 0;
    int        stall_left = 0;
    int        in_calm = 0;
    int        out_calm = 0;

    // shadow of the block's registers and filter state
    logic [WEIGHT_W-1:0]      reg_weight;
    logic [OFFSET_W-1:0]      reg_offset;
    logic [SLOPE_W-1:0]       reg_slope;
    logic [WARMUP_W-1:0]      reg_warmup;
    logic signed [COMP_W-1:0] reg_comp;
    logic [TEMP_W-1:0]        avg_temp;
    logic [TEMP_W-1:0]        base_temp;
    logic [PRESS_W-1:0]       avg_press;
    logic [PRESS_W-1:0]       base_press;
    logic [WARMUP_W-1:0]      warm_count;
    logic                     base_locked;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    task automatic filter_reset();
        reg_weight  = WEIGHT_RST;
        reg_offset  = OFFSET_RST;
        reg_slope   = SLOPE_RST;
        reg_warmup  = WARMUP_RST;
        reg_comp    = COMP_RST;
        avg_temp    = '0;
        base_temp   = '0;
        avg_press   = '0;
        base_press  = '0;
        warm_count  = '0;
        base_locked = 1'b0;
    endtask

    function automatic longint unsigned ema(longint unsigned avg, longint unsigned smp,
                                            longint unsigned wt);
        return (wt * smp + (256 - wt) * avg + 128) >> SMOOTH_SHIFT;
    endfunction

    function automatic t_out_word predict_reading(t_in_word w);
        longint unsigned wt, t_smp, p_drop, p_smp;
        longint          ta, tb, pa, pb, prod, chg, alt;
        t_out_word       r;
        wt = 64'((reg_weight > WEIGHT_MAX) ? WEIGHT_MAX : reg_weight);
        t_smp = 64'(w.raw_temperature);
        t_smp = t_smp << TEMP_FRAC_DEF;
        if (t_smp > 64'hFFFF_FFFF) t_smp = 64'hFFFF_FFFF;
        p_drop = 64'(reg_slope);
        p_drop = (p_drop * 64'(w.raw_pressure) + 32768) >> PRESS_SHIFT;
        p_smp = (p_drop >= 64'(reg_offset)) ? 0 : 64'(reg_offset) - p_drop;
        avg_temp  = TEMP_W'(ema(64'(avg_temp), t_smp, wt));
        avg_press = PRESS_W'(ema(64'(avg_press), p_smp, wt));
        if (!base_locked) begin
            if (warm_count < WARM_MAX) warm_count = warm_count + 1'b1;
            if (warm_count >= reg_warmup) begin
                base_temp   = avg_temp;
                base_press  = avg_press;
                base_locked = 1'b1;
            end
        end
        chg = 0;
        alt = 0;
        if (base_locked) begin
            ta = 64'(avg_temp);
            tb = 64'(base_temp);
            pa = 64'(avg_press);
            pb = 64'(base_press);
            prod = ((ta - tb) * 64'(reg_comp) + 128) >>> TEMP_FRAC_DEF;
            chg = (pa - pb) + prod;
            if (chg > CHG_MAX) chg = 64'(CHG_MAX);
            if (chg < CHG_MIN) chg = 64'(CHG_MIN);
            alt = -10 * chg;
            if (alt > ALT_HI) alt = ALT_HI;
            if (alt < ALT_LO) alt = ALT_LO;
        end
        r.smooth_temperature = avg_temp;
        r.smooth_pressure    = avg_press;
        r.pressure_change    = chg[CHANGE_W-1:0];
        r.altitude           = alt[ALT_W-1:0];
        r.baseline_ready     = base_locked;
        return r;
    endfunction

    task automatic check_field(string name, longint unsigned want, longint unsigned got);
        if (want != got) begin
            n_errors++;
            if (n_errors <= 10)
                $display("reading %0d: %s expected %0h got %0h", n_readings, name, want, got);
        end
    endtask

    function automatic int draw_gap(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 11);
    endfunction

    // monitor: register shadow, prediction on accept, comparison on result
    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            filter_reset();
            in_fire  <= 1'b0;
            out_fire <= 1'b0;
        end else begin
            in_fire  <= i_in_valid && o_in_ready;
            out_fire <= o_out_valid && i_out_ready;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_WEIGHT: reg_weight = i_cfg_data[WEIGHT_W-1:0];
                    CFG_OFFSET: reg_offset = i_cfg_data[OFFSET_W-1:0];
                    CFG_SLOPE:  reg_slope  = i_cfg_data[SLOPE_W-1:0];
                    CFG_WARMUP: reg_warmup = i_cfg_data[WARMUP_W-1:0];
                    CFG_COMP:   reg_comp   = i_cfg_data[COMP_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && o_in_ready) begin
                reading_q.push_back(predict_reading(i_in_word));
                n_samples_taken++;
            end
            if (o_out_valid && i_out_ready) begin
                n_readings++;
                if (reading_q.size() == 0) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("reading %0d: unexpected word %0h", n_readings, o_out_word);
                end else begin
                    want = reading_q.pop_front();
                    check_field("smooth_temperature", 64'(want.smooth_temperature),
                                64'(o_out_word.smooth_temperature));
                    check_field("smooth_pressure", 64'(want.smooth_pressure),
                                64'(o_out_word.smooth_pressure));
                    check_field("pressure_change", 64'(want.pressure_change),
                                64'(o_out_word.pressure_change));
                    check_field("altitude", 64'(want.altitude), 64'(o_out_word.altitude));
                    check_field("baseline_ready", 64'(want.baseline_ready),
                                64'(o_out_word.baseline_ready));
                end
            end
        end
    end

    // sample driver
    always @(negedge i_clk) begin
        if (in_fire) gap_left = draw_gap(in_calm);
        if (!i_in_valid || in_fire) begin
            if (gap_left != 0) begin
                i_in_valid <= 1'b0;
                gap_left--;
            end else if (sample_q.size() != 0) begin
                i_in_word  <= sample_q.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // reading sink back-pressure
    always @(negedge i_clk) begin
        if (out_fire) stall_left = draw_gap(out_calm);
        if (stall_left != 0) begin
            i_out_ready <= 1'b0;
            stall_left--;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // call only right after a posedge
    task automatic queue_sample(logic [RAW_W-1:0] raw_t, logic [RAW_W-1:0] raw_p);
        t_in_word w;
        w.raw_temperature = raw_t;
        w.raw_pressure    = raw_p;
        sample_q.push_back(w);
        n_samples_queued++;
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (n_samples_taken != n_samples_queued || reading_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_reg(int width, longint unsigned rst);
        logic [CFG_DATA_W-1:0] mask, v, junk;
        mask = (27'd1 << width) - 1'b1;
        case ($urandom_range(0, 5))
            0: v = '0;
            1: v = mask;
            2, 3: v = CFG_DATA_W'(rst);
            default: v = CFG_DATA_W'($urandom) & mask;
        endcase
        junk = ($urandom_range(0, 3) == 0) ? (CFG_DATA_W'($urandom) & ~mask) : '0;
        return v | junk;
    endfunction

    task automatic random_config();
        logic [CFG_DATA_W-1:0] wt;
        case ($urandom_range(0, 5))
            0: wt = '0;
            1: wt = CFG_DATA_W'(WEIGHT_MAX);
            2: wt = CFG_DATA_W'($urandom_range(257, 511));
            default: wt = CFG_DATA_W'($urandom_range(1, 255));
        endcase
        cfg_write(CFG_WEIGHT, wt);
        cfg_write(CFG_OFFSET, pick_reg(OFFSET_W, 64'(OFFSET_RST)));
        cfg_write(CFG_SLOPE, pick_reg(SLOPE_W, 64'(SLOPE_RST)));
        cfg_write(CFG_WARMUP, pick_reg(WARMUP_W, 64'(WARMUP_RST)));
        cfg_write(CFG_COMP, pick_reg(COMP_W, 64'($urandom_range(0, 4096))));
        if ($urandom_range(0, 2) == 0)
            cfg_write(CFG_IDX_W'($urandom_range(CFG_UNUSED_LO, CFG_UNUSED_HI)),
                      CFG_DATA_W'($urandom));
    endtask

    function automatic logic [RAW_W-1:0] noisy(logic [RAW_W-1:0] center);
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2, 3: return RAW_W'($urandom);
            default: return center + RAW_W'($urandom_range(0, 511)) - 24'd256;
        endcase
    endfunction

    task automatic random_phase(int count);
        logic [RAW_W-1:0] t_center, p_center;
        t_center = RAW_W'($urandom);
        p_center = RAW_W'($urandom);
        @(posedge i_clk);
        repeat (count) queue_sample(noisy(t_center), noisy(p_center));
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // longest warm-up, then cut short mid-way through it
        cfg_write(CFG_WARMUP, CFG_DATA_W'(WARM_MAX));
        cfg_write(CFG_UNUSED_LO, '1);
        cfg_write(CFG_UNUSED_HI, '1);
        @(posedge i_clk);
        queue_sample('0, '0);
        queue_sample('1, '1);
        queue_sample('1, '0);
        queue_sample('0, '1);
        wait_idle();

        // full weight and zero warm-up: baseline latches at temperature zero
        cfg_write(CFG_WEIGHT, CFG_DATA_W'(WEIGHT_MAX));
        cfg_write(CFG_WARMUP, '0);
        @(posedge i_clk);
        queue_sample('0, 24'h80_0000);
        wait_idle();

        // big temperature swing against extreme compensation saturates the change
        cfg_write(CFG_COMP, 27'h07F_FFFF);
        cfg_write(CFG_WARMUP, CFG_DATA_W'(WARM_MAX));
        @(posedge i_clk);
        queue_sample('1, 24'h80_0000);
        wait_idle();
        cfg_write(CFG_COMP, 27'h080_0000);
        @(posedge i_clk);
        queue_sample('1, 24'h80_0000);
        queue_sample(24'h00_0001, 24'h7F_FFFF);
        wait_idle();

        // weight above full scale, converted pressure clamped at zero
        cfg_write(CFG_WEIGHT, '1);
        cfg_write(CFG_COMP, '0);
        cfg_write(CFG_OFFSET, '0);
        cfg_write(CFG_SLOPE, '1);
        @(posedge i_clk);
        queue_sample(24'h12_3456, '1);
        queue_sample('0, '0);
        wait_idle();

        // zero weight holds the averages
        cfg_write(CFG_WEIGHT, '0);
        cfg_write(CFG_OFFSET, '1);
        cfg_write(CFG_SLOPE, '0);
        @(posedge i_clk);
        queue_sample('1, '1);
        queue_sample(24'h55_5555, 24'hAA_AAAA);
        wait_idle();

        cfg_write(CFG_WEIGHT, 27'd1);
        cfg_write(CFG_COMP, 27'h0FF_FFFF);
        cfg_write(CFG_OFFSET, OFFSET_RST);
        cfg_write(CFG_SLOPE, CFG_DATA_W'(SLOPE_RST));
        @(posedge i_clk);
        queue_sample(24'hAA_AAAA, 24'h55_5555);
        queue_sample(24'h00_00FF, 24'h01_0000);
        wait_idle();

        repeat (8) begin
            random_config();
            random_phase(62);
            wait_idle();
        end

        if (n_errors == 0 && reading_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
